// ===== design/css_pkg.sv =====
`timescale 1ns / 1ps

package css_pkg;

	localparam int unsigned VALUE_W = 16;
	localparam int unsigned FUNC_W  = 2;
	localparam int unsigned SEG_W   = 7;
	localparam int unsigned EN_W    = 4;
	localparam int unsigned DIGIT_W = 4;

	typedef enum logic [FUNC_W-1:0] {
		FUNC_SCAN  = 2'd0,
		FUNC_INC   = 2'd1,
		FUNC_CLEAR = 2'd2,
		FUNC_RX    = 2'd3
	} func_t;

	typedef struct packed {
		logic [VALUE_W-1:0] count;
		logic [EN_W-1:0]    digit_enable;
		logic [SEG_W-1:0]   segments_n;
	} result_t;

	// lit segments a..g (bits 0..6), active high
	function automatic logic [SEG_W-1:0] seg_lit(input logic [DIGIT_W-1:0] digit);
		logic [SEG_W-1:0] seg;
		case (digit)
			4'd0:    seg = 7'h3F;
			4'd1:    seg = 7'h06;
			4'd2:    seg = 7'h5B;
			4'd3:    seg = 7'h4F;
			4'd4:    seg = 7'h66;
			4'd5:    seg = 7'h6D;
			4'd6:    seg = 7'h7D;
			4'd7:    seg = 7'h27;
			4'd8:    seg = 7'h7F;
			4'd9:    seg = 7'h6F;
			default: seg = 7'h3F;
		endcase
		return seg;
	endfunction

	function automatic longint unsigned pow10(input int k);
		longint unsigned p;
		p = 1;
		for (int i = 0; i < k; i++) begin
			p = p * 10;
		end
		return p;
	endfunction

endpackage

// ===== design/css_dec_split.sv =====
`timescale 1ns / 1ps

// Splits a 16-bit value into its low DIGIT_COUNT decimal digits.
// Each q[k] = v / 10^k, 0 < k < 5, has its own reciprocal multiply
// (exact for all 16-bit inputs); digit k is q[k] - 10*q[k+1].
module css_dec_split #(
	parameter int DIGIT_COUNT = 4
) (
	input  logic [css_pkg::VALUE_W-1:0]                  value,
	output logic [DIGIT_COUNT-1:0][css_pkg::DIGIT_W-1:0] digits
);

	logic [DIGIT_COUNT:0][css_pkg::VALUE_W-1:0] quot;

	for (genvar k = 0; k <= DIGIT_COUNT; k++) begin : g_quot
		localparam longint unsigned DIV = css_pkg::pow10(k);
		if (k == 0) begin : g_unit
			assign quot[k] = value;
		end else if (DIV > 64'd65535) begin : g_zero
			assign quot[k] = '0;
		end else begin : g_recip
			localparam int SHIFT_L = $clog2(DIV);
			localparam int SHIFT   = css_pkg::VALUE_W + SHIFT_L;
			localparam logic [css_pkg::VALUE_W:0] RECIP =
				(css_pkg::VALUE_W+1)'(((64'd1 << SHIFT) / DIV) + 64'd1);
			logic [2*css_pkg::VALUE_W:0] prod;
			assign prod    = {{(css_pkg::VALUE_W+1){1'b0}}, value}
			               * {{css_pkg::VALUE_W{1'b0}}, RECIP};
			assign quot[k] = css_pkg::VALUE_W'(prod >> SHIFT);
		end
	end

	// most significant digit sits at index 0
	for (genvar i = 0; i < DIGIT_COUNT; i++) begin : g_digit
		localparam int K = DIGIT_COUNT - 1 - i;
		logic [css_pkg::VALUE_W-1:0] rem;
		assign rem       = quot[K] - ((quot[K+1] << 3) + (quot[K+1] << 1));
		assign digits[i] = rem[css_pkg::DIGIT_W-1:0];
	end

endmodule

// ===== design/css_datapath.sv =====
`timescale 1ns / 1ps

// Counter, received-value shadow, scan position and shown digits.
// State moves on adv; result reflects the state after the item.
module css_datapath #(
	parameter int DIGIT_COUNT = 4
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          adv,
	input  css_pkg::func_t                func,
	input  logic [css_pkg::VALUE_W-1:0]   rx_value,
	output css_pkg::result_t              result
);

	localparam int POS_W = (DIGIT_COUNT > 1) ? $clog2(DIGIT_COUNT) : 1;
	localparam logic [POS_W-1:0] POS_LAST = POS_W'(DIGIT_COUNT - 1);

	logic [css_pkg::VALUE_W-1:0]                  counter_q, counter_nxt;
	logic [css_pkg::VALUE_W-1:0]                  last_rx_q, last_rx_nxt;
	logic [POS_W-1:0]                             pos_q, pos_nxt;
	logic [DIGIT_COUNT-1:0][css_pkg::DIGIT_W-1:0] digits_q, digits_nxt, split_digits;
	logic [css_pkg::DIGIT_W-1:0]                  sel_digit;

	css_dec_split #(
		.DIGIT_COUNT(DIGIT_COUNT)
	) u_split (
		.value (counter_q),
		.digits(split_digits)
	);

	always_comb begin
		counter_nxt = counter_q;
		last_rx_nxt = last_rx_q;
		pos_nxt     = pos_q;
		digits_nxt  = digits_q;
		case (func)
			css_pkg::FUNC_SCAN: begin
				if (pos_q == POS_LAST) begin
					pos_nxt    = '0;
					digits_nxt = split_digits;
				end else begin
					pos_nxt = pos_q + 1'b1;
				end
			end
			css_pkg::FUNC_INC: begin
				counter_nxt = counter_q + 1'b1;
			end
			css_pkg::FUNC_CLEAR: begin
				counter_nxt = '0;
			end
			css_pkg::FUNC_RX: begin
				if (rx_value != last_rx_q) begin
					counter_nxt = rx_value;
				end
				last_rx_nxt = rx_value;
			end
			default: begin
				counter_nxt = counter_q;
			end
		endcase
	end

	assign sel_digit = digits_nxt[pos_nxt];

	always_comb begin
		result.count      = counter_nxt;
		result.segments_n = ~css_pkg::seg_lit(sel_digit);
		for (int j = 0; j < css_pkg::EN_W; j++) begin
			result.digit_enable[j] = (32'(pos_nxt) == j);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			counter_q <= '0;
			last_rx_q <= '0;
			pos_q     <= '0;
			for (int i = 0; i < DIGIT_COUNT; i++) begin
				digits_q[i] <= css_pkg::DIGIT_W'((i + 1) % 10);
			end
		end else if (adv) begin
			counter_q <= counter_nxt;
			last_rx_q <= last_rx_nxt;
			pos_q     <= pos_nxt;
			digits_q  <= digits_nxt;
		end
	end

endmodule

// ===== design/counter_seven_segment_scanner_top.sv =====
`timescale 1ns / 1ps

// Event counter shown in decimal on a multiplexed seven-segment display.
// Input stream: s_tuser carries the item kind (scan tick, second tick,
// button clear, received value); s_tdata carries the received value.
// Every input transaction yields exactly one output transaction on m_*:
// active-low segments for the selected digit, the one-hot digit enable
// (bit 0 = most significant digit) and the counter after the item.
// A scan tick steps the digit select; on wrap to the first digit the
// counter is snapshotted into DIGIT_COUNT decimal digits (count modulo
// 10^DIGIT_COUNT).
// Pipeline: input register (s1), then one pass of logic (state update,
// reciprocal-multiply decimal split, segment decode) into the output
// register. Throughput is one transaction per cycle while m_tready
// does not stall the output, set by the single state update per cycle.
// A stalled m_tready holds the output register; s1 still takes one more
// transaction, then s_tready drops until the output drains.
// Reset clears the counter, the received-value shadow and the digit
// select; the shown digits reset to 1, 2, 3, 4 ...
module counter_seven_segment_scanner_top #(
	parameter int DIGIT_COUNT = 4
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [15:0] s_tdata,   // [15:0] rx_value
	input  logic [1:0]  s_tuser,   // [1:0] func
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [31:0] m_tdata    // [6:0] segments_n, [10:7] digit_enable,
	                               // [26:11] count, [31:27] zero
);

	logic                        s1_valid_q;
	logic [1:0]                  func_s1;
	logic [css_pkg::VALUE_W-1:0] rx_value_s1;
	logic                        adv;
	css_pkg::result_t            result;
	css_pkg::result_t            result_s2;
	logic                        m_valid_q;

	// item in s1 moves on when the output register is free or draining
	assign adv      = s1_valid_q && (!m_valid_q || m_tready);
	assign s_tready = !s1_valid_q || adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid_q <= 1'b0;
		end else if (s_tvalid && s_tready) begin
			s1_valid_q <= 1'b1;
		end else if (adv) begin
			s1_valid_q <= 1'b0;
		end
	end

	// payload, no reset needed
	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			func_s1     <= s_tuser;
			rx_value_s1 <= s_tdata;
		end
	end

	css_datapath #(
		.DIGIT_COUNT(DIGIT_COUNT)
	) u_datapath (
		.clk     (clk),
		.arst_n  (arst_n),
		.adv     (adv),
		.func    (css_pkg::func_t'(func_s1)),
		.rx_value(rx_value_s1),
		.result  (result)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_valid_q <= 1'b0;
		end else if (adv) begin
			m_valid_q <= 1'b1;
		end else if (m_tready) begin
			m_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			result_s2 <= result;
		end
	end

	assign m_tvalid = m_valid_q;
	assign m_tdata  = {5'b0, result_s2.count, result_s2.digit_enable, result_s2.segments_n};

endmodule
